[design/fmsu_pkg.sv]
`timescale 1ns / 1ps
package fmsu_pkg;

  localparam int STRAIN_W  = 32;
  localparam int COEF_W    = 32;
  localparam int STRESS_W  = 48;
  localparam int CFG_IDX_W = 4;

  localparam logic signed [COEF_W-1:0] DIR_X_RESET = 32'sh4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAME_ISO    = 4'd0,
    REG_SHEAR_ISO   = 4'd1,
    REG_FIBER_ALPHA = 4'd2,
    REG_FIBER_BETA  = 4'd3,
    REG_FIBER_GAMMA = 4'd4,
    REG_DIR_X       = 4'd5,
    REG_DIR_Y       = 4'd6,
    REG_DIR_Z       = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [STRAIN_W-1:0] strain_xx;
    logic signed [STRAIN_W-1:0] strain_yy;
    logic signed [STRAIN_W-1:0] strain_zz;
    logic signed [STRAIN_W-1:0] shear_yz;
    logic signed [STRAIN_W-1:0] shear_xz;
    logic signed [STRAIN_W-1:0] shear_xy;
  } in_word_t;

  typedef struct packed {
    logic signed [STRESS_W-1:0] stress_xx;
    logic signed [STRESS_W-1:0] stress_yy;
    logic signed [STRESS_W-1:0] stress_zz;
    logic signed [STRESS_W-1:0] stress_yz;
    logic signed [STRESS_W-1:0] stress_xz;
    logic signed [STRESS_W-1:0] stress_xy;
    logic                       saturated;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;
  } cfg_word_t;

endpackage

[design/fmsu_if.sv]
`timescale 1ns / 1ps
interface fmsu_in_if import fmsu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fmsu_out_if import fmsu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fmsu_cfg_if import fmsu_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/fiber_material_stress_update.sv]
`timescale 1ns / 1ps
// Each accepted strain word passes through every stage register to its stress word.
// Throughput: one word per cycle; each stage holds when the stage after it is
// full and stalled, so bubbles close up and nothing is lost or repeated.
// Reset (synchronous, rst_n low): clears every stage valid bit and returns the
// coefficient registers to zero and the fibre direction to (1, 0, 0).
module fiber_material_stress_update import fmsu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  fmsu_in_if.sink    in_ch,
  fmsu_out_if.source out_ch,
  fmsu_cfg_if.sink   cfg_ch
);

  localparam int NSTG = 12;
  localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};
  localparam logic signed [37:0] ONE28  = 38'sd268435456;
  localparam logic signed [37:0] THREE28 = 38'sd805306368;

  logic signed [31:0] lam_r, g_r, alpha_r, beta_r, gam_r;
  logic signed [31:0] a_r [3];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r   <= '0;
      g_r     <= '0;
      alpha_r <= '0;
      beta_r  <= '0;
      gam_r   <= '0;
      a_r[0]  <= DIR_X_RESET;
      a_r[1]  <= '0;
      a_r[2]  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.data.index))
        REG_LAME_ISO:    lam_r   <= cfg_ch.data.data;
        REG_SHEAR_ISO:   g_r     <= cfg_ch.data.data;
        REG_FIBER_ALPHA: alpha_r <= cfg_ch.data.data;
        REG_FIBER_BETA:  beta_r  <= cfg_ch.data.data;
        REG_FIBER_GAMMA: gam_r   <= cfg_ch.data.data;
        REG_DIR_X:       a_r[0]  <= cfg_ch.data.data;
        REG_DIR_Y:       a_r[1]  <= cfg_ch.data.data;
        REG_DIR_Z:       a_r[2]  <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_ch.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = v_r[NSTG-1];

  // stage 0: input word
  logic signed [31:0] e_r [6];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      e_r[0] <= in_ch.data.strain_xx;
      e_r[1] <= in_ch.data.strain_yy;
      e_r[2] <= in_ch.data.strain_zz;
      e_r[3] <= in_ch.data.shear_yz;
      e_r[4] <= in_ch.data.shear_xz;
      e_r[5] <= in_ch.data.shear_xy;
    end
  end

  // stage 1: C.a products, direction products, isotropic terms
  logic signed [34:0] c_m [3][3];
  logic signed [66:0] pm_m [3][3];
  logic signed [63:0] pa_m [6];
  logic signed [33:0] tr_m;
  logic signed [32:0] e2_m [3];
  logic signed [65:0] piso_m;
  logic signed [64:0] pgd_m [3];
  logic signed [63:0] pgs_m [3];
  logic signed [36:0] m_nxt [3][3], m_r [3][3];
  logic signed [36:0] i1_nxt, i1_r;
  logic signed [33:0] p_nxt [6];
  logic signed [37:0] iso_nxt;
  logic signed [36:0] gd_nxt [3];
  logic signed [35:0] gs_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e2_m[i]   = e_r[i];
      e2_m[i]   = e2_m[i] <<< 1;
      c_m[i][i] = e_r[i];
      c_m[i][i] = (c_m[i][i] <<< 1) + 35'(ONE28);
    end
    c_m[0][1] = e_r[5];
    c_m[1][0] = e_r[5];
    c_m[0][2] = e_r[4];
    c_m[2][0] = e_r[4];
    c_m[1][2] = e_r[3];
    c_m[2][1] = e_r[3];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm_m[i][j]  = c_m[i][j] * a_r[j];
        m_nxt[i][j] = pm_m[i][j][66:30];
      end
    end
    i1_nxt = 37'(c_m[0][0]) + 37'(c_m[1][1]) + 37'(c_m[2][2]);
    for (int k = 0; k < 6; k++) begin
      pa_m[k]  = a_r[PI[k]] * a_r[PJ[k]];
      p_nxt[k] = pa_m[k][63:30];
    end
    tr_m    = 34'(e_r[0]) + 34'(e_r[1]) + 34'(e_r[2]);
    piso_m  = lam_r * tr_m;
    iso_nxt = piso_m[65:28];
    for (int i = 0; i < 3; i++) begin
      pgd_m[i]  = g_r * e2_m[i];
      gd_nxt[i] = pgd_m[i][64:28];
      pgs_m[i]  = g_r * e_r[3+i];
      gs_nxt[i] = pgs_m[i][63:28];
    end
  end

  logic signed [33:0] p1_r [6];
  logic signed [37:0] iso1_r;
  logic signed [36:0] gd1_r [3];
  logic signed [35:0] gs1_r [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m_r    <= m_nxt;
      i1_r   <= i1_nxt;
      p1_r   <= p_nxt;
      iso1_r <= iso_nxt;
      gd1_r  <= gd_nxt;
      gs1_r  <= gs_nxt;
    end
  end

  // stage 2: C.a
  logic signed [38:0] ca_nxt [3], ca_r [3];
  logic signed [36:0] i1b_r;
  logic signed [33:0] p2_r [6];
  logic signed [37:0] iso2_r;
  logic signed [36:0] gd2_r [3];
  logic signed [35:0] gs2_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca_nxt[i] = 39'(m_r[i][0]) + 39'(m_r[i][1]) + 39'(m_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ca_r   <= ca_nxt;
      i1b_r  <= i1_r;
      p2_r   <= p1_r;
      iso2_r <= iso1_r;
      gd2_r  <= gd1_r;
      gs2_r  <= gs1_r;
    end
  end

  // stage 3: (C.a) x a products, beta term of I1
  logic signed [70:0] pq_m [3][3];
  logic signed [37:0] i1m3_m;
  logic signed [69:0] pbt_m;
  logic signed [40:0] qa_nxt [3][3], qa_r [3][3];
  logic signed [41:0] bt_nxt, bt3_r;
  logic signed [33:0] p3_r [6];
  logic signed [37:0] iso3_r;
  logic signed [36:0] gd3_r [3];
  logic signed [35:0] gs3_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pq_m[i][j]   = ca_r[i] * a_r[j];
        qa_nxt[i][j] = pq_m[i][j][70:30];
      end
    end
    i1m3_m = 38'(i1b_r) - THREE28;
    pbt_m  = beta_r * i1m3_m;
    bt_nxt = pbt_m[69:28];
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      qa_r   <= qa_nxt;
      bt3_r  <= bt_nxt;
      p3_r   <= p2_r;
      iso3_r <= iso2_r;
      gd3_r  <= gd2_r;
      gs3_r  <= gs2_r;
    end
  end

  // stage 4: I4 - 1 and symmetric q
  logic signed [43:0] i4m1_nxt, i4m1_r;
  logic signed [41:0] q_nxt [6], q_r [6];
  logic signed [41:0] bt4_r;
  logic signed [33:0] p4_r [6];
  logic signed [37:0] iso4_r;
  logic signed [36:0] gd4_r [3];
  logic signed [35:0] gs4_r [3];

  always_comb begin
    i4m1_nxt = 44'(qa_r[0][0]) + 44'(qa_r[1][1]) + 44'(qa_r[2][2]) - 44'(ONE28);
    for (int k = 0; k < 6; k++) begin
      q_nxt[k] = 42'(qa_r[PI[k]][PJ[k]]) + 42'(qa_r[PJ[k]][PI[k]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      i4m1_r <= i4m1_nxt;
      q_r    <= q_nxt;
      bt4_r  <= bt3_r;
      p4_r   <= p3_r;
      iso4_r <= iso3_r;
      gd4_r  <= gd3_r;
      gs4_r  <= gs3_r;
    end
  end

  // stage 5: partial products of beta, gamma and alpha terms
  logic signed [53:0] bh_nxt, gh_nxt, bh_r, gh_r;
  logic signed [54:0] bl_nxt, gl_nxt, bl_r, gl_r;
  logic signed [52:0] ah_nxt [6], ah_r [6];
  logic signed [53:0] al_nxt [6], al_r [6];
  logic signed [41:0] bt5_r;
  logic signed [33:0] p5_r [6];
  logic signed [37:0] iso5_r;
  logic signed [36:0] gd5_r [3];
  logic signed [35:0] gs5_r [3];

  always_comb begin
    bh_nxt = beta_r * $signed(i4m1_r[43:22]);
    bl_nxt = beta_r * $signed({1'b0, i4m1_r[21:0]});
    gh_nxt = gam_r * $signed(i4m1_r[43:22]);
    gl_nxt = gam_r * $signed({1'b0, i4m1_r[21:0]});
    for (int k = 0; k < 6; k++) begin
      ah_nxt[k] = alpha_r * $signed(q_r[k][41:21]);
      al_nxt[k] = alpha_r * $signed({1'b0, q_r[k][20:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      bh_r   <= bh_nxt;
      bl_r   <= bl_nxt;
      gh_r   <= gh_nxt;
      gl_r   <= gl_nxt;
      ah_r   <= ah_nxt;
      al_r   <= al_nxt;
      bt5_r  <= bt4_r;
      p5_r   <= p4_r;
      iso5_r <= iso4_r;
      gd5_r  <= gd4_r;
      gs5_r  <= gs4_r;
    end
  end

  // stage 6: merge partial products
  logic signed [75:0] fb_m, fg_m;
  logic signed [73:0] fa_m [6];
  logic signed [47:0] bm_nxt, gm_nxt, bm_r, gm_r;
  logic signed [45:0] aq_nxt [6], aq6_r [6];
  logic signed [41:0] bt6_r;
  logic signed [33:0] p6_r [6];
  logic signed [37:0] iso6_r;
  logic signed [36:0] gd6_r [3];
  logic signed [35:0] gs6_r [3];

  always_comb begin
    fb_m   = bh_r;
    fb_m   = (fb_m <<< 22) + 76'(bl_r);
    bm_nxt = fb_m[75:28];
    fg_m   = gh_r;
    fg_m   = (fg_m <<< 22) + 76'(gl_r);
    gm_nxt = fg_m[75:28];
    for (int k = 0; k < 6; k++) begin
      fa_m[k]   = ah_r[k];
      fa_m[k]   = (fa_m[k] <<< 21) + 74'(al_r[k]);
      aq_nxt[k] = fa_m[k][73:28];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      bm_r   <= bm_nxt;
      gm_r   <= gm_nxt;
      aq6_r  <= aq_nxt;
      bt6_r  <= bt5_r;
      p6_r   <= p5_r;
      iso6_r <= iso5_r;
      gd6_r  <= gd5_r;
      gs6_r  <= gs5_r;
    end
  end

  // stage 7: c2 and c3
  logic signed [50:0] c3h_m;
  logic signed [48:0] c2_nxt, c2_7_r;
  logic signed [51:0] c3_nxt, c3_r;
  logic signed [45:0] aq7_r [6];
  logic signed [33:0] p7_r [6];
  logic signed [37:0] iso7_r;
  logic signed [36:0] gd7_r [3];
  logic signed [35:0] gs7_r [3];

  always_comb begin
    c2_nxt = bm_r;
    c2_nxt = c2_nxt <<< 1;
    c3h_m  = gm_r;
    c3h_m  = (c3h_m <<< 1) + 51'(alpha_r) + 51'(bt6_r);
    c3_nxt = c3h_m;
    c3_nxt = c3_nxt <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      c2_7_r <= c2_nxt;
      c3_r   <= c3_nxt;
      aq7_r  <= aq6_r;
      p7_r   <= p6_r;
      iso7_r <= iso6_r;
      gd7_r  <= gd6_r;
      gs7_r  <= gs6_r;
    end
  end

  // stage 8: partial products of c3 with a x a
  logic signed [59:0] ch_nxt [6], ch_r [6];
  logic signed [60:0] cl_nxt [6], cl_r [6];
  logic signed [48:0] c2_8_r;
  logic signed [45:0] aq8_r [6];
  logic signed [37:0] iso8_r;
  logic signed [36:0] gd8_r [3];
  logic signed [35:0] gs8_r [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ch_nxt[k] = $signed(c3_r[51:26]) * p7_r[k];
      cl_nxt[k] = $signed({1'b0, c3_r[25:0]}) * p7_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      ch_r   <= ch_nxt;
      cl_r   <= cl_nxt;
      c2_8_r <= c2_7_r;
      aq8_r  <= aq7_r;
      iso8_r <= iso7_r;
      gd8_r  <= gd7_r;
      gs8_r  <= gs7_r;
    end
  end

  // stage 9: fibre stress
  logic signed [85:0] fc_m [6];
  logic signed [57:0] sf_nxt [6], sf_r [6];
  logic signed [37:0] iso9_r;
  logic signed [36:0] gd9_r [3];
  logic signed [35:0] gs9_r [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      fc_m[k]   = ch_r[k];
      fc_m[k]   = (fc_m[k] <<< 26) + 86'(cl_r[k]);
      sf_nxt[k] = 58'($signed(fc_m[k][85:30])) - 58'(aq8_r[k]);
      if (PI[k] == PJ[k]) begin
        sf_nxt[k] = sf_nxt[k] + 58'(c2_8_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      sf_r   <= sf_nxt;
      iso9_r <= iso8_r;
      gd9_r  <= gd8_r;
      gs9_r  <= gs8_r;
    end
  end

  // stage 10: add isotropic part
  logic signed [59:0] res_nxt [6], res_r [6];

  always_comb begin
    res_nxt[0] = 60'(iso9_r) + 60'(gd9_r[0]) + 60'(sf_r[0]);
    res_nxt[1] = 60'(iso9_r) + 60'(gd9_r[1]) + 60'(sf_r[3]);
    res_nxt[2] = 60'(iso9_r) + 60'(gd9_r[2]) + 60'(sf_r[5]);
    res_nxt[3] = 60'(gs9_r[0]) + 60'(sf_r[4]);
    res_nxt[4] = 60'(gs9_r[1]) + 60'(sf_r[2]);
    res_nxt[5] = 60'(gs9_r[2]) + 60'(sf_r[1]);
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      res_r <= res_nxt;
    end
  end

  // stage 11: clip to output range
  logic signed [STRESS_W-1:0] clip_m [6];
  logic [5:0]                 sat_m;
  out_word_t                  out_nxt, out_r;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sat_m[k] = !((&res_r[k][59:STRESS_W-1]) || !(|res_r[k][59:STRESS_W-1]));
      if (!sat_m[k]) begin
        clip_m[k] = res_r[k][STRESS_W-1:0];
      end else if (res_r[k][59]) begin
        clip_m[k] = {1'b1, {(STRESS_W-1){1'b0}}};
      end else begin
        clip_m[k] = {1'b0, {(STRESS_W-1){1'b1}}};
      end
    end
    out_nxt.stress_xx = clip_m[0];
    out_nxt.stress_yy = clip_m[1];
    out_nxt.stress_zz = clip_m[2];
    out_nxt.stress_yz = clip_m[3];
    out_nxt.stress_xz = clip_m[4];
    out_nxt.stress_xy = clip_m[5];
    out_nxt.saturated = |sat_m;
  end

  always_ff @(posedge clk) begin
    if (rdy[11]) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.data = out_r;

endmodule
